FILE: src/pbs_pkg.sv
// Package for the packed bitmap pixel store: sizes, codes and the word types
// shared by the front end, the queue, the back end and the top level.
// Depends on nothing.
`timescale 1ns / 1ps

package pbs_pkg;

  localparam int unsigned STORE_BYTES = 65536;
  localparam int unsigned MAX_DIM     = 4096;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam int DIM_W       = 13;
  localparam int COORD_W     = 12;
  localparam int COLOR_W     = 24;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 13;
  localparam int WBITS_W     = DIM_W + 5;
  localparam int ROW_WORDS_W = 12;
  localparam int PROD_W      = COORD_W + ROW_WORDS_W;
  localparam int XOFF_W      = COORD_W + 2;
  localparam int SPAN_W      = PROD_W + 3;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic MODE_WRITE = 1'b1;

  typedef enum logic [1:0] {
    FMT_1BPP  = 2'd0,
    FMT_4BPP  = 2'd1,
    FMT_8BPP  = 2'd2,
    FMT_24BPP = 2'd3
  } fmt_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PIXEL_FORMAT = 4'd0,
    REG_IMAGE_WIDTH  = 4'd1,
    REG_IMAGE_HEIGHT = 4'd2,
    REG_TOP_DOWN     = 4'd3
  } reg_idx_t;

  typedef struct packed {
    logic               mode;
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [COLOR_W-1:0] color_value;
  } in_word_t;

  typedef struct packed {
    logic [COLOR_W-1:0] read_value;
    logic               range_error;
  } out_word_t;

  typedef struct packed {
    logic               mode;
    logic               err;
    fmt_t               fmt;
    logic [ADDR_W-1:0]  addr;
    logic [2:0]         sub;
    logic [COLOR_W-1:0] color;
  } q_entry_t;

endpackage

FILE: src/pbs_front.sv
// Front end of the pixel store: configuration registers, range check and
// byte address computation in two stages. Depends on pbs_pkg.
`timescale 1ns / 1ps

module pbs_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_valid,
  input  logic [pbs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pbs_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  pbs_pkg::in_word_t          in_word,
  input  logic                       init_done,
  input  logic                       q_full,
  output logic                       q_push,
  output pbs_pkg::q_entry_t          q_data
);
  import pbs_pkg::*;

  fmt_t             fmt_r;
  logic [DIM_W-1:0] width_r;
  logic [DIM_W-1:0] height_r;
  logic             top_down_r;

  logic                   s1_v_r;
  logic                   s1_mode_r;
  logic                   s1_err_r;
  fmt_t                   s1_fmt_r;
  logic [COORD_W-1:0]     s1_row_r;
  logic [ROW_WORDS_W-1:0] s1_words_r;
  logic [XOFF_W-1:0]      s1_xoff_r;
  logic [2:0]             s1_sub_r;
  logic [COLOR_W-1:0]     s1_color_r;

  logic                   s2_v_r;
  logic                   s2_mode_r;
  logic                   s2_err_r;
  fmt_t                   s2_fmt_r;
  logic [PROD_W-1:0]      s2_prod_r;
  logic [XOFF_W-1:0]      s2_xoff_r;
  logic [2:0]             s2_sub_r;
  logic [COLOR_W-1:0]     s2_color_r;

  logic                   adv;
  logic                   accept;
  logic                   oob;
  logic [WBITS_W-1:0]     wbits;
  logic [ROW_WORDS_W-1:0] words;
  logic [COORD_W-1:0]     row;
  logic [XOFF_W-1:0]      xoff;
  logic [SPAN_W-1:0]      first;
  logic [SPAN_W-1:0]      last;
  logic                   past;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r      <= FMT_8BPP;
      width_r    <= DIM_W'(1);
      height_r   <= DIM_W'(1);
      top_down_r <= 1'b0;
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_PIXEL_FORMAT: fmt_r      <= fmt_t'(cfg_data[1:0]);
        REG_IMAGE_WIDTH:  width_r    <= cfg_data[DIM_W-1:0];
        REG_IMAGE_HEIGHT: height_r   <= cfg_data[DIM_W-1:0];
        REG_TOP_DOWN:     top_down_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign adv      = !(s2_v_r && q_full);
  assign in_stall = !init_done || !adv;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    unique case (fmt_r)
      FMT_1BPP: begin
        wbits = WBITS_W'(width_r);
        xoff  = XOFF_W'(in_word.pixel_x >> 3);
      end
      FMT_4BPP: begin
        wbits = WBITS_W'(width_r) << 2;
        xoff  = XOFF_W'(in_word.pixel_x >> 1);
      end
      FMT_8BPP: begin
        wbits = WBITS_W'(width_r) << 3;
        xoff  = XOFF_W'(in_word.pixel_x);
      end
      default: begin
        wbits = (WBITS_W'(width_r) << 4) + (WBITS_W'(width_r) << 3);
        xoff  = (XOFF_W'(in_word.pixel_x) << 1) + XOFF_W'(in_word.pixel_x);
      end
    endcase
    words = ROW_WORDS_W'((wbits + WBITS_W'(31)) >> 5);
    row   = top_down_r ? in_word.pixel_y
                       : COORD_W'(height_r - DIM_W'(1) - DIM_W'(in_word.pixel_y));
    oob   = (width_r == '0) || (height_r == '0) ||
            (width_r > DIM_W'(MAX_DIM)) || (height_r > DIM_W'(MAX_DIM)) ||
            (DIM_W'(in_word.pixel_x) >= width_r) ||
            (DIM_W'(in_word.pixel_y) >= height_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= accept;
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_mode_r  <= in_word.mode;
      s1_err_r   <= oob;
      s1_fmt_r   <= fmt_r;
      s1_row_r   <= row;
      s1_words_r <= words;
      s1_xoff_r  <= xoff;
      s1_sub_r   <= in_word.pixel_x[2:0];
      s1_color_r <= in_word.color_value;
      s2_mode_r  <= s1_mode_r;
      s2_err_r   <= s1_err_r;
      s2_fmt_r   <= s1_fmt_r;
      s2_prod_r  <= PROD_W'(s1_row_r) * PROD_W'(s1_words_r);
      s2_xoff_r  <= s1_xoff_r;
      s2_sub_r   <= s1_sub_r;
      s2_color_r <= s1_color_r;
    end
  end

  always_comb begin
    first = SPAN_W'({s2_prod_r, 2'b00}) + SPAN_W'(s2_xoff_r);
    last  = first + ((s2_fmt_r == FMT_24BPP) ? SPAN_W'(2) : SPAN_W'(0));
    past  = last >= SPAN_W'(STORE_BYTES);
    q_push       = s2_v_r && !q_full;
    q_data.mode  = s2_mode_r;
    q_data.err   = s2_err_r || past;
    q_data.fmt   = s2_fmt_r;
    q_data.addr  = first[ADDR_W-1:0];
    q_data.sub   = s2_sub_r;
    q_data.color = s2_color_r;
  end

endmodule

FILE: src/pbs_queue.sv
// Short queue of decoded pixel accesses between the front and back ends.
// Depends on pbs_pkg.
`timescale 1ns / 1ps

module pbs_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  pbs_pkg::q_entry_t push_data,
  input  logic              pop,
  output logic              full,
  output logic              empty,
  output pbs_pkg::q_entry_t head
);
  import pbs_pkg::*;

  q_entry_t          slots_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_push;
  logic              do_pop;

  assign full    = count_r == QCNT_W'(QUEUE_DEPTH);
  assign empty   = count_r == '0;
  assign head    = slots_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: src/pbs_back.sv
// Back end of the pixel store: the byte memory, its clearing pass after
// reset, the read-modify-write sequencer and the result register.
// Depends on pbs_pkg.
`timescale 1ns / 1ps

module pbs_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  pbs_pkg::q_entry_t head,
  output logic              q_pop,
  output logic              init_done,
  output logic              out_valid,
  input  logic              out_stall,
  output pbs_pkg::out_word_t out_word
);
  import pbs_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_RD    = 4'b0100,
    ST_WR    = 4'b1000
  } state_t;

  logic [7:0] mem [STORE_BYTES];

  state_t            state_r, state_nxt;
  q_entry_t          cur_r, cur_nxt;
  logic [1:0]        cnt_r, cnt_nxt;
  logic [15:0]       acc_r, acc_nxt;
  logic [ADDR_W-1:0] clr_r, clr_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_word_t         out_word_r;
  logic [7:0]        rd_q_r;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_wa;
  logic [7:0]        mem_wd;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_ra;
  logic              load_out;
  out_word_t         res;
  logic              out_free;
  logic [7:0]        mod_byte;

  assign out_free  = !out_valid_r || !out_stall;
  assign init_done = state_r != ST_CLEAR;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  always_comb begin
    mod_byte = rd_q_r;
    if (cur_r.fmt == FMT_1BPP) begin
      mod_byte[~cur_r.sub] = cur_r.color[0];
    end else if (cur_r.sub[0]) begin
      mod_byte = {rd_q_r[7:4], cur_r.color[3:0]};
    end else begin
      mod_byte = {cur_r.color[3:0], rd_q_r[3:0]};
    end
  end

  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    cnt_nxt   = cnt_r;
    acc_nxt   = acc_r;
    clr_nxt   = clr_r;
    q_pop     = 1'b0;
    mem_we    = 1'b0;
    mem_wa    = cur_r.addr;
    mem_wd    = '0;
    mem_re    = 1'b0;
    mem_ra    = head.addr;
    load_out  = 1'b0;
    res       = '0;
    unique case (state_r)
      ST_CLEAR: begin
        mem_we  = 1'b1;
        mem_wa  = clr_r;
        clr_nxt = clr_r + ADDR_W'(1);
        if (clr_r == ADDR_W'(STORE_BYTES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!q_empty && out_free) begin
          q_pop   = 1'b1;
          cur_nxt = head;
          cnt_nxt = '0;
          if (head.err) begin
            load_out        = 1'b1;
            res.range_error = 1'b1;
          end else if (head.mode == MODE_WRITE) begin
            case (head.fmt)
              FMT_8BPP: begin
                mem_we   = 1'b1;
                mem_wa   = head.addr;
                mem_wd   = head.color[7:0];
                load_out = 1'b1;
              end
              FMT_24BPP: begin
                mem_we    = 1'b1;
                mem_wa    = head.addr;
                mem_wd    = head.color[7:0];
                cnt_nxt   = 2'd1;
                state_nxt = ST_WR;
              end
              default: begin
                mem_re    = 1'b1;
                state_nxt = ST_RD;
              end
            endcase
          end else begin
            mem_re    = 1'b1;
            state_nxt = ST_RD;
          end
        end
      end
      ST_RD: begin
        if (cur_r.mode == MODE_WRITE) begin
          mem_we    = 1'b1;
          mem_wd    = mod_byte;
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          case (cur_r.fmt)
            FMT_1BPP: begin
              res.read_value = COLOR_W'(rd_q_r[~cur_r.sub]);
              load_out       = 1'b1;
              state_nxt      = ST_IDLE;
            end
            FMT_4BPP: begin
              res.read_value = COLOR_W'(cur_r.sub[0] ? rd_q_r[3:0] : rd_q_r[7:4]);
              load_out       = 1'b1;
              state_nxt      = ST_IDLE;
            end
            FMT_8BPP: begin
              res.read_value = COLOR_W'(rd_q_r);
              load_out       = 1'b1;
              state_nxt      = ST_IDLE;
            end
            default: begin
              if (cnt_r == 2'd2) begin
                res.read_value = {rd_q_r, acc_r};
                load_out       = 1'b1;
                state_nxt      = ST_IDLE;
              end else begin
                if (cnt_r == 2'd0) begin
                  acc_nxt[7:0] = rd_q_r;
                end else begin
                  acc_nxt[15:8] = rd_q_r;
                end
                mem_re  = 1'b1;
                mem_ra  = cur_r.addr + ADDR_W'(cnt_r) + ADDR_W'(1);
                cnt_nxt = cnt_r + 2'd1;
              end
            end
          endcase
        end
      end
      ST_WR: begin
        mem_we = 1'b1;
        mem_wa = cur_r.addr + ADDR_W'(cnt_r);
        mem_wd = (cnt_r == 2'd1) ? cur_r.color[15:8] : cur_r.color[23:16];
        if (cnt_r == 2'd2) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + 2'd1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    acc_r <= acc_nxt;
    if (load_out) begin
      out_word_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_q_r <= mem[mem_ra];
    end
  end

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty && state_r == ST_IDLE)
    else $error("queue popped while empty or busy");

  a_load_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> !out_valid_r || !out_stall)
    else $error("result overwrote an untaken word");

  a_error_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && head.err) |-> !mem_we && !mem_re)
    else $error("rejected access touched the store");

  a_wide_write_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WR |-> cnt_r != 2'd0 && cur_r.fmt == FMT_24BPP)
    else $error("24-bit write sequence out of step");

  a_clear_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR && clr_r == ADDR_W'(STORE_BYTES - 1)) |=> state_r == ST_IDLE)
    else $error("clearing pass did not end");

endmodule

FILE: src/packed_bitmap_pixel_store_core.sv
// Top level of the packed bitmap pixel store: front end, access queue and
// back end with the byte memory. Depends on pbs_pkg, pbs_front, pbs_queue
// and pbs_back.
//
// Usage: the input channel carries one pixel access per word (in_valid,
// in_stall, in_word); the result channel returns exactly one word per access
// in the same order (out_valid, out_stall, out_word). Configuration writes go
// through cfg_valid, cfg_ready, cfg_index and cfg_data; cfg_ready is always
// high, and registers should change only while no access is in flight.
// After reset the store is swept to zero, one byte per cycle; in_stall
// stays high during the sweep. The back end finishes a rejected access or
// an 8-bit write from the idle state; a 1, 4 or 8-bit read or a 1 or 4-bit
// write first reads its byte (read-modify-write of one byte for a write); a
// 24-bit write and a 24-bit read handle their three bytes one after another,
// all bound by one byte access at a time to the memory.
// A two-word queue lets the front end keep accepting while the back end
// works. When the receiver stalls, the result word holds and the queue and
// front pipeline fill up before in_stall rises.
`timescale 1ns / 1ps

module packed_bitmap_pixel_store_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  pbs_pkg::in_word_t              in_word,
  output logic                           out_valid,
  input  logic                           out_stall,
  output pbs_pkg::out_word_t             out_word,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pbs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pbs_pkg::CFG_DATA_W-1:0] cfg_data
);
  import pbs_pkg::*;

  logic     init_done;
  logic     q_full;
  logic     q_empty;
  logic     q_push;
  logic     q_pop;
  q_entry_t q_data;
  q_entry_t q_head;

  assign cfg_ready = 1'b1;

  pbs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .init_done (init_done),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_data)
  );

  pbs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .pop       (q_pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (q_head)
  );

  pbs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .head      (q_head),
    .q_pop     (q_pop),
    .init_done (init_done),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

FILE: dv/tb_packed_bitmap_pixel_store_core.sv
// Self-checking testbench for packed_bitmap_pixel_store_core: pixel reads and writes
// across formats, sizes and row orders, checked against a byte-level model of the store.
// Depends on pbs_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_packed_bitmap_pixel_store_core;
  import pbs_pkg::*;

  localparam int unsigned IDLE_LIMIT    = 200000;
  localparam int unsigned RANDOM_ITEMS  = 1800;
  localparam int unsigned SETTLE_CYCLES = 10;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned DIM_CEIL      = (1 << DIM_W) - 1;
  localparam int unsigned COORD_MAX     = (1 << COORD_W) - 1;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 4'hF;
  localparam logic MODE_READ = 1'b0;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_word_t              in_word = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_word_t             out_word;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  fmt_t             cur_fmt = FMT_8BPP;
  logic [DIM_W-1:0] cur_width = DIM_W'(1);
  logic [DIM_W-1:0] cur_height = DIM_W'(1);
  logic             cur_top_down = 1'b0;
  bit [7:0]         shadow_bytes [STORE_BYTES];

  in_word_t  pixel_requests[$];
  out_word_t expected_pixel_results[$];
  out_word_t oldest_result;

  int unsigned mismatches = 0;
  int unsigned items_accepted = 0;
  int unsigned writes_done = 0;
  int unsigned reads_done = 0;
  int unsigned rejects_seen = 0;
  int unsigned results_checked = 0;
  int unsigned reg_writes = 0;
  int unsigned setups = 0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned hold_left = 0;
  int unsigned holds_done = 0;
  int unsigned stall_epoch = 0;
  int unsigned stall_style = 0;
  int unsigned idle_cycles = 0;

  packed_bitmap_pixel_store_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 40) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
  endtask

  function automatic out_word_t predict_pixel_access(input in_word_t req);
    out_word_t   res;
    int unsigned bpp;
    int unsigned wd;
    int unsigned ht;
    int unsigned px;
    int unsigned py;
    int unsigned row;
    int unsigned first;
    int unsigned last;
    int unsigned bitpos;
    res.read_value = '0;
    res.range_error = 1'b1;
    wd = cur_width;
    ht = cur_height;
    px = req.pixel_x;
    py = req.pixel_y;
    case (cur_fmt)
      FMT_1BPP: bpp = 1;
      FMT_4BPP: bpp = 4;
      FMT_8BPP: bpp = 8;
      default:  bpp = 24;
    endcase
    if (wd == 0 || ht == 0 || wd > MAX_DIM || ht > MAX_DIM || px >= wd || py >= ht) begin
      return res;
    end
    row = cur_top_down ? py : ht - 1 - py;
    first = row * ((((wd * bpp) + 31) >> 5) * 4);
    case (bpp)
      1:       first += px >> 3;
      4:       first += px >> 1;
      8:       first += px;
      default: first += px * 3;
    endcase
    last = first + ((bpp == 24) ? 2 : 0);
    if (last >= STORE_BYTES) begin
      return res;
    end
    res.range_error = 1'b0;
    bitpos = 7 - (px & 7);
    if (req.mode == MODE_WRITE) begin
      case (bpp)
        1: shadow_bytes[first][bitpos] = req.color_value[0];
        4: begin
          if (px & 1) begin
            shadow_bytes[first][3:0] = req.color_value[3:0];
          end else begin
            shadow_bytes[first][7:4] = req.color_value[3:0];
          end
        end
        8: shadow_bytes[first] = req.color_value[7:0];
        default: begin
          shadow_bytes[first]     = req.color_value[7:0];
          shadow_bytes[first + 1] = req.color_value[15:8];
          shadow_bytes[first + 2] = req.color_value[23:16];
        end
      endcase
    end else begin
      case (bpp)
        1: res.read_value = COLOR_W'(shadow_bytes[first][bitpos]);
        4: res.read_value = COLOR_W'((px & 1) ? shadow_bytes[first][3:0]
                                              : shadow_bytes[first][7:4]);
        8: res.read_value = COLOR_W'(shadow_bytes[first]);
        default: res.read_value = {shadow_bytes[first + 2], shadow_bytes[first + 1],
                                   shadow_bytes[first]};
      endcase
    end
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_pixel_results.push_back(predict_pixel_access(in_word));
        items_accepted++;
        if (in_word.mode == MODE_WRITE) begin
          writes_done++;
        end else begin
          reads_done++;
        end
      end
      if (!(in_valid && in_stall)) begin
        if (burst_left == 0 && gap_left == 0) begin
          burst_left = $urandom_range(1, 48);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
        if (burst_left > 0 && pixel_requests.size() > 0) begin
          in_word <= pixel_requests.pop_front();
          in_valid <= 1'b1;
          burst_left--;
        end else begin
          in_valid <= 1'b0;
          if (burst_left == 0 && gap_left > 0) begin
            gap_left--;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_checked++;
        if (out_word.range_error === 1'b1) begin
          rejects_seen++;
        end
        if (expected_pixel_results.size() == 0) begin
          report_mismatch($sformatf("result word %h with no access outstanding", out_word));
        end else begin
          oldest_result = expected_pixel_results.pop_front();
          if (out_word.read_value !== oldest_result.read_value) begin
            report_mismatch($sformatf("read_value %h, expected %h",
                                      out_word.read_value, oldest_result.read_value));
          end
          if (out_word.range_error !== oldest_result.range_error) begin
            report_mismatch($sformatf("range_error %b, expected %b",
                                      out_word.range_error, oldest_result.range_error));
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (holds_done < 2 && results_checked >= 300 + 800 * holds_done && in_valid) begin
        hold_left = HOLD_CYCLES - 1;
        holds_done++;
        out_stall <= 1'b1;
      end else begin
        if (stall_epoch == 0) begin
          stall_style = $urandom_range(0, 2);
          stall_epoch = $urandom_range(16, 96);
        end else begin
          stall_epoch--;
        end
        case (stall_style)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Watchdog: no handshake for %0d cycles, %0d results outstanding.",
               idle_cycles, expected_pixel_results.size());
      $display("** packed_bitmap_pixel_store_core: FAILED **");
      $finish;
    end else begin
      idle_cycles++;
    end
  end

  task automatic queue_pixel(input logic mode, input int unsigned x, input int unsigned y,
                             input int unsigned color);
    in_word_t req;
    req.mode = mode;
    req.pixel_x = COORD_W'(x);
    req.pixel_y = COORD_W'(y);
    req.color_value = COLOR_W'(color);
    pixel_requests.push_back(req);
  endtask

  // Sampled at the falling edge so that the driver's updates from the last rising edge are seen.
  task automatic wait_idle();
    while (pixel_requests.size() != 0 || in_valid || expected_pixel_results.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    reg_writes++;
    case (idx)
      REG_PIXEL_FORMAT: cur_fmt = fmt_t'(data[1:0]);
      REG_IMAGE_WIDTH:  cur_width = data;
      REG_IMAGE_HEIGHT: cur_height = data;
      REG_TOP_DOWN:     cur_top_down = data[0];
      default: ;
    endcase
  endtask

  // The upper data bits of the narrow registers are random so that their masking is exercised.
  task automatic apply_setup(input fmt_t fmt, input int unsigned wd, input int unsigned ht,
                             input bit td);
    logic [CFG_DATA_W-1:0] data;
    wait_idle();
    data = CFG_DATA_W'($urandom);
    data[1:0] = fmt;
    write_register(REG_PIXEL_FORMAT, data);
    write_register(REG_IMAGE_WIDTH, CFG_DATA_W'(wd));
    write_register(REG_IMAGE_HEIGHT, CFG_DATA_W'(ht));
    write_register(REG_UNMAPPED, CFG_DATA_W'($urandom));
    data = CFG_DATA_W'($urandom);
    data[0] = td;
    write_register(REG_TOP_DOWN, data);
    cfg_valid <= 1'b0;
    setups++;
  endtask

  function automatic int unsigned pick_dim();
    case ($urandom_range(0, 11))
      0:       return 1;
      1:       return MAX_DIM;
      2:       return $urandom_range(0, 1) ? 0 : $urandom_range(MAX_DIM + 1, DIM_CEIL);
      3:       return $urandom_range(1, MAX_DIM);
      default: return $urandom_range(1, 48);
    endcase
  endfunction

  initial begin
    int unsigned random_items;
    int unsigned wd;
    int unsigned ht;
    int unsigned x;
    int unsigned y;
    int unsigned last_x;
    int unsigned last_y;
    int unsigned pick;
    int unsigned count;
    bit          dims_ok;
    random_items = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // The store is swept to zero after reset; in_stall covers the sweep.
    while (in_stall !== 1'b0) @(posedge clk);

    queue_pixel(MODE_READ, 0, 0, 0);
    queue_pixel(MODE_WRITE, 0, 0, 24'hABCDEF);
    queue_pixel(MODE_READ, 0, 0, 0);
    queue_pixel(MODE_READ, 1, 0, 0);
    queue_pixel(MODE_WRITE, 0, 1, 24'hFFFFFF);
    queue_pixel(MODE_READ, COORD_MAX, COORD_MAX, 24'hFFFFFF);

    apply_setup(FMT_1BPP, MAX_DIM, MAX_DIM, 1'b1);
    queue_pixel(MODE_WRITE, COORD_MAX, 0, 1);
    queue_pixel(MODE_READ, COORD_MAX, 0, 0);
    queue_pixel(MODE_WRITE, 0, 0, 24'hFFFFFE);
    queue_pixel(MODE_READ, 0, 0, 0);
    queue_pixel(MODE_WRITE, 6, 127, 1);
    queue_pixel(MODE_READ, 7, 127, 0);
    queue_pixel(MODE_WRITE, 0, 128, 1);

    apply_setup(FMT_4BPP, 3, 2, 1'b0);
    queue_pixel(MODE_WRITE, 0, 0, 24'hFFFFF5);
    queue_pixel(MODE_WRITE, 1, 0, 24'h00000A);
    queue_pixel(MODE_READ, 0, 0, 0);
    queue_pixel(MODE_READ, 1, 0, 0);
    queue_pixel(MODE_READ, 3, 0, 0);

    apply_setup(FMT_24BPP, MAX_DIM, MAX_DIM, 1'b0);
    queue_pixel(MODE_WRITE, 0, 0, 24'h010203);
    queue_pixel(MODE_WRITE, COORD_MAX, COORD_MAX, 24'hFFFFFF);
    queue_pixel(MODE_READ, COORD_MAX, COORD_MAX, 0);
    queue_pixel(MODE_WRITE, 0, 4091, 24'h123456);
    queue_pixel(MODE_READ, 0, 4091, 0);

    apply_setup(FMT_8BPP, 0, 4, 1'b1);
    queue_pixel(MODE_READ, 0, 0, 0);
    apply_setup(FMT_8BPP, DIM_CEIL, 4, 1'b1);
    queue_pixel(MODE_READ, 0, 0, 0);

    while (random_items < RANDOM_ITEMS) begin
      wd = pick_dim();
      ht = pick_dim();
      apply_setup(fmt_t'($urandom_range(0, 3)), wd, ht, 1'($urandom_range(0, 1)));
      dims_ok = wd >= 1 && wd <= MAX_DIM && ht >= 1 && ht <= MAX_DIM;
      count = dims_ok ? $urandom_range(40, 110) : 12;
      last_x = 0;
      last_y = 0;
      repeat (count) begin
        pick = $urandom_range(0, 19);
        if (dims_ok && pick < 4) begin
          x = last_x;
          y = last_y;
        end else if (dims_ok && pick < 14) begin
          x = $urandom_range(0, wd - 1);
          y = $urandom_range(0, ht - 1);
          last_x = x;
          last_y = y;
        end else if (dims_ok && pick < 16) begin
          x = (wd < MAX_DIM && pick == 14) ? wd : wd - 1;
          y = (ht < MAX_DIM && $urandom_range(0, 1)) ? ht : ht - 1;
        end else begin
          x = $urandom_range(0, COORD_MAX);
          y = $urandom_range(0, COORD_MAX);
        end
        queue_pixel(1'($urandom_range(0, 1)), x, y, $urandom_range(0, 24'hFFFFFF));
        random_items++;
      end
    end

    wait_idle();
    $display("Covered %0d pixel accesses (%0d writes, %0d reads, %0d rejected) over %0d setups.",
             items_accepted, writes_done, reads_done, rejects_seen, setups);
    $display("%0d register writes; receiver held off for long stretches %0d times.",
             reg_writes, holds_done);
    if (mismatches == 0) begin
      $display("** packed_bitmap_pixel_store_core: PASSED **");
    end else begin
      $display("** packed_bitmap_pixel_store_core: FAILED **");
    end
    $finish;
  end

endmodule
